/* design/fanmon_pkg.sv */
// ----------------------------------------------------------------------------
// fanmon_pkg
// Shared types, constants and helpers for the fan speed frame alert monitor.
// ----------------------------------------------------------------------------
package fanmon_pkg;

	localparam int SLOT_COUNT = 4;
	localparam int FAN_COUNT  = 4;

	typedef logic [15:0] speed_t;
	typedef logic [31:0] msec_t;

	// frame characters
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// register indexes
	localparam logic [2:0] REG_THR0  = 3'd0;
	localparam logic [2:0] REG_THR1  = 3'd1;
	localparam logic [2:0] REG_THR2  = 3'd2;
	localparam logic [2:0] REG_THR3  = 3'd3;
	localparam logic [2:0] REG_STALE = 3'd4;
	localparam logic [2:0] REG_REARM = 3'd5;

	localparam speed_t STALE_RESET = 16'd3000;
	localparam speed_t REARM_RESET = 16'd1000;

	localparam logic [2:0] FIELD_LAST = 3'(SLOT_COUNT);

	// item function codes
	localparam logic FUNC_BYTE  = 1'b0;
	localparam logic FUNC_WATCH = 1'b1;

	typedef enum logic [2:0] {
		FP_IDLE  = 3'd0,
		FP_HDR_R = 3'd1,
		FP_HDR_F = 3'd2,
		FP_SKIP  = 3'd3,
		FP_BODY  = 3'd4
	} frame_pos_t;

	typedef struct packed {
		logic [SLOT_COUNT-1:0][15:0] thr;
		speed_t                      stale_ms;
		speed_t                      rearm_ms;
	} cfg_t;

	typedef struct packed {
		logic                        valid;
		logic [SLOT_COUNT-1:0][15:0] speed;
	} commit_t;

	// value * 10 + digit, saturated to 16 bits
	function automatic speed_t digit_accum(input speed_t p, input logic [7:0] c);
		logic [19:0] v;
		v = {1'b0, p, 3'b000} + {3'b000, p, 1'b0} + {16'd0, c[3:0]};
		return (v > 20'd65535) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

/* design/fanmon_cfg_regs.sv */
// ----------------------------------------------------------------------------
// fanmon_cfg_regs
// Threshold, stale timeout and rearm delay registers.
// ----------------------------------------------------------------------------
module fanmon_cfg_regs import fanmon_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr      <= '0;
			cfg_q.stale_ms <= STALE_RESET;
			cfg_q.rearm_ms <= REARM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THR0:  cfg_q.thr[0]   <= cfg_data;
				REG_THR1:  cfg_q.thr[1]   <= cfg_data;
				REG_THR2:  cfg_q.thr[2]   <= cfg_data;
				REG_THR3:  cfg_q.thr[3]   <= cfg_data;
				REG_STALE: cfg_q.stale_ms <= cfg_data;
				REG_REARM: cfg_q.rearm_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/fanmon_parser.sv */
// ----------------------------------------------------------------------------
// fanmon_parser
// Frame parser: header check, field split and decimal accumulation.
// ----------------------------------------------------------------------------
module fanmon_parser import fanmon_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  logic [7:0] rx_byte,
	output commit_t    commit
);

	frame_pos_t                  pos_q, pos_n;
	logic                        good_q, good_n;
	logic [2:0]                  fidx_q, fidx_n;
	logic                        closed_q, closed_n;
	logic [SLOT_COUNT-1:0][15:0] pend_q, pend_n;

	logic is_digit;
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

	// next state
	always_comb begin
		pos_n    = pos_q;
		good_n   = good_q;
		fidx_n   = fidx_q;
		closed_n = closed_q;
		pend_n   = pend_q;
		if (byte_en) begin
			if (rx_byte == CH_HASH) begin
				pos_n    = FP_HDR_R;
				good_n   = 1'b1;
				fidx_n   = '0;
				closed_n = 1'b0;
				pend_n   = '0;
			end else if (pos_q != FP_IDLE) begin
				if (rx_byte == CH_NL) begin
					pos_n = FP_IDLE;
				end else begin
					unique case (pos_q)
						FP_HDR_R: begin
							if (rx_byte != CH_R) good_n = 1'b0;
							pos_n = FP_HDR_F;
						end
						FP_HDR_F: begin
							if (rx_byte != CH_F) good_n = 1'b0;
							pos_n = FP_SKIP;
						end
						FP_SKIP: pos_n = FP_BODY;
						FP_BODY: begin
							if (rx_byte == CH_COMMA) begin
								if (fidx_q < FIELD_LAST) fidx_n = fidx_q + 3'd1;
								closed_n = 1'b0;
							end else if (is_digit) begin
								if (!closed_q) begin
									for (int i = 0; i < SLOT_COUNT; i++) begin
										if (i < FAN_COUNT && fidx_q == 3'(i))
											pend_n[i] = digit_accum(pend_q[i], rx_byte);
									end
								end
							end else begin
								closed_n = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	// commit on newline once the header is through
	always_comb begin
		commit.valid = byte_en && (rx_byte == CH_NL) && good_q &&
		               (pos_q == FP_SKIP || pos_q == FP_BODY);
		for (int i = 0; i < SLOT_COUNT; i++)
			commit.speed[i] = (i < FAN_COUNT) ? pend_q[i] : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= FP_IDLE;
			good_q   <= 1'b0;
			fidx_q   <= '0;
			closed_q <= 1'b0;
			pend_q   <= '0;
		end else begin
			pos_q    <= pos_n;
			good_q   <= good_n;
			fidx_q   <= fidx_n;
			closed_q <= closed_n;
			pend_q   <= pend_n;
		end
	end

endmodule

/* design/fanmon_alert.sv */
// ----------------------------------------------------------------------------
// fanmon_alert
// Current speeds, frame time stamp, stale check, blink phase and alerts.
// ----------------------------------------------------------------------------
module fanmon_alert import fanmon_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        watch_en,
	input  msec_t                       now_ms,
	input  commit_t                     commit,
	input  cfg_t                        cfg,
	output logic [SLOT_COUNT-1:0][15:0] speed_next,
	output logic [SLOT_COUNT-1:0]       alert_next,
	output logic                        blink_next
);

	logic [SLOT_COUNT-1:0][15:0] speed_q, speed_n;
	logic [SLOT_COUNT-1:0][31:0] start_q, start_n;
	logic [SLOT_COUNT-1:0]       alert_q, alert_n;
	msec_t                       last_q, last_n;
	logic                        blink_q, blink_n;
	logic                        stale;

	assign stale = (now_ms - last_q) >= {16'd0, cfg.stale_ms};

	always_comb begin
		speed_n = speed_q;
		start_n = start_q;
		alert_n = alert_q;
		last_n  = last_q;
		blink_n = blink_q;
		if (commit.valid) begin
			speed_n = commit.speed;
			last_n  = now_ms;
		end else if (watch_en) begin
			if (stale) speed_n = '0;
			blink_n = !blink_q;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (i < FAN_COUNT) begin
					if (speed_n[i] < cfg.thr[i]) begin
						if (!alert_q[i] &&
						    (now_ms - start_q[i]) >= {16'd0, cfg.rearm_ms}) begin
							start_n[i] = now_ms;
							alert_n[i] = 1'b1;
						end
					end else begin
						alert_n[i] = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			start_q <= '0;
			alert_q <= '0;
			last_q  <= '0;
			blink_q <= 1'b0;
		end else begin
			speed_q <= speed_n;
			start_q <= start_n;
			alert_q <= alert_n;
			last_q  <= last_n;
			blink_q <= blink_n;
		end
	end

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			speed_next[i] = (i < FAN_COUNT) ? speed_n[i] : 16'd0;
			alert_next[i] = (i < FAN_COUNT) ? alert_n[i] : 1'b0;
		end
	end
	assign blink_next = blink_n;

endmodule

/* design/fan_rpm_frame_alert_monitor_top.sv */
// ----------------------------------------------------------------------------
// fan_rpm_frame_alert_monitor_top
// Fan speed frame parser and low-speed alert monitor, one result per item.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the input register; its result is
//   registered when the input stage moves and shown on the output from then on.
// Throughput: one item per cycle; the input stage moves whenever the result
//   register is empty or being taken.
// Reset: arst_n clears parse and alert state, speeds and the blink phase;
//   thresholds reset to 0, stale timeout to 3000, rearm delay to 1000.
module fan_rpm_frame_alert_monitor_top import fanmon_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] speed0,
	output logic [15:0] speed1,
	output logic [15:0] speed2,
	output logic [15:0] speed3,
	output logic [3:0]  alert_mask,
	output logic [3:0]  highlight_mask,
	output logic        blink_on,
	output logic        any_alert,
	output logic        frame_done,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;
	msec_t      now_s1;

	logic       valid_s2;
	logic [SLOT_COUNT-1:0][15:0] speed_s2;
	logic [SLOT_COUNT-1:0]       alert_s2;
	logic       blink_s2;
	logic       done_s2;

	logic       advance;
	logic       in_take;
	cfg_t       cfg;
	commit_t    commit;
	logic [SLOT_COUNT-1:0][15:0] speed_next;
	logic [SLOT_COUNT-1:0]       alert_next;
	logic       blink_next;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	fanmon_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fanmon_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (advance && func_s1 == FUNC_BYTE),
		.rx_byte (byte_s1),
		.commit  (commit)
	);

	fanmon_alert u_alert (
		.clk        (clk),
		.arst_n     (arst_n),
		.watch_en   (advance && func_s1 == FUNC_WATCH),
		.now_ms     (now_s1),
		.commit     (commit),
		.cfg        (cfg),
		.speed_next (speed_next),
		.alert_next (alert_next),
		.blink_next (blink_next)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1 <= func;
			byte_s1 <= rx_byte;
			now_s1  <= now_ms;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			speed_s2 <= speed_next;
			alert_s2 <= alert_next;
			blink_s2 <= blink_next;
			done_s2  <= commit.valid;
		end
	end

	assign out_valid      = valid_s2;
	assign speed0         = speed_s2[0];
	assign speed1         = speed_s2[1];
	assign speed2         = speed_s2[2];
	assign speed3         = speed_s2[3];
	assign alert_mask     = alert_s2;
	assign highlight_mask = blink_s2 ? alert_s2 : 4'b0000;
	assign blink_on       = blink_s2;
	assign any_alert      = |alert_s2;
	assign frame_done     = done_s2;

	// input stage only holds back when it is occupied
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// an item leaving the input register always lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result missing after input stage moved");

	// a committed frame never comes from a watch pass
	a_done_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		commit.valid |-> (advance && func_s1 == FUNC_BYTE))
		else $error("frame commit outside a byte item");

	// a blocked result holds the input stage occupied
	a_block_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |=> valid_s1)
		else $error("input item dropped while result stalled");

endmodule
